[sv/pip_pkg.sv]
// shared types and constants for the point in polygon test
`default_nettype none

package pip_pkg;

    // coordinate, edge difference, product, vertex count and index widths
    localparam int COORD_W = 18;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // sequencer strobes towards the edge unit
    typedef struct packed {
        logic prime;    // take the wrap vertex as the previous one
        logic load;     // take the current vertex and form the differences
        logic mul_lhs;  // (px - xi) * dy through the multiplier
        logic mul_rhs;  // (xj - xi) * (py - yi) through the multiplier
    } edge_ctrl_t;

endpackage

`default_nettype wire

[sv/point_in_polygon_test.sv]
// top level: vertex store, edge walk sequencer and result register
// a vertex write beat is taken while idle, writes one slot and gives no result
// a query walks n = min(vertex_count, MAX_VERTICES) edges, each edge through the load
// and the two multiply steps on the shared multiplier, then a finish step gives the result
// the next beat is taken back in idle; a count of zero skips the walk and goes to finish
// rst_n clears the sequencer, the count and the result; the vertex store is not cleared
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pip_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [pip_pkg::INDEX_W-1:0]   vertex_index,
    input  wire pip_pkg::coord_t               coord_x,
    input  wire pip_pkg::coord_t               coord_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               inside_res
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > pip_pkg::COUNT_W) ? CW : pip_pkg::COUNT_W;
    localparam int IW = AW + pip_pkg::INDEX_W;
    localparam int RW = 2 * pip_pkg::COORD_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRIME  = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [pip_pkg::COUNT_W-1:0] count_reg;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               last_reg, last_next;
    logic                        pending_reg, pending_next;
    logic                        flag_reg, flag_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        inside_reg, inside_next;
    pip_pkg::coord_t             px_reg;
    pip_pkg::coord_t             py_reg;

    logic                        in_beat;
    logic                        wr_beat;
    logic                        qry_beat;
    logic [NW-1:0]               cnt_wide;
    logic [CW-1:0]               n_sat;
    logic [IW-1:0]               idx_wide;
    logic                        idx_ok;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [RW-1:0]               ram_rdata;
    pip_pkg::coord_t             rd_x;
    pip_pkg::coord_t             rd_y;
    pip_pkg::edge_ctrl_t         ctrl;
    logic                        toggle;
    logic                        last_edge;
    logic                        final_flag;

    // handshake and beat decode
    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign wr_beat   = in_beat && (mode == MODE_WRITE);
    assign qry_beat  = in_beat && (mode == MODE_QUERY);
    assign out_valid = out_valid_reg;
    assign inside_res = inside_reg;

    // vertex count saturated to the table size
    assign cnt_wide = NW'(count_reg);
    assign n_sat    = (cnt_wide > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cnt_wide);

    // write slot, dropped beyond the table
    assign idx_wide = IW'(vertex_index);
    assign idx_ok   = idx_wide < IW'(MAX_VERTICES);
    assign ram_we   = wr_beat && idx_ok;

    // vertex store, x in the low half and y in the high half
    pip_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_wide[AW-1:0]),
        .wdata ({coord_y, coord_x}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[pip_pkg::COORD_W-1:0];
    assign rd_y = ram_rdata[RW-1:pip_pkg::COORD_W];

    assign last_edge = (idx_reg == last_reg);

    // read address: wrap vertex on the query beat, then each vertex in turn
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        if (qry_beat)
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(n_sat - CW'(1));
        end
        else if (state_reg == S_PRIME)
        begin
            ram_re    = 1'b1;
            ram_raddr = '0;
        end
        else if ((state_reg == S_MUL2) && !last_edge)
        begin
            ram_re    = 1'b1;
            ram_raddr = idx_reg + AW'(1);
        end
    end

    // edge unit strobes
    always_comb
    begin
        ctrl.prime   = (state_reg == S_PRIME);
        ctrl.load    = (state_reg == S_LOAD);
        ctrl.mul_lhs = (state_reg == S_MUL1);
        ctrl.mul_rhs = (state_reg == S_MUL2);
    end

    pip_edge_unit u_edge (
        .clk    (clk),
        .ctrl   (ctrl),
        .px     (px_reg),
        .py     (py_reg),
        .vx     (rd_x),
        .vy     (rd_y),
        .toggle (toggle)
    );

    assign final_flag = flag_reg ^ (pending_reg && toggle);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        pending_next   = pending_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        inside_next    = inside_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (qry_beat)
                begin
                    idx_next     = '0;
                    last_next    = AW'(n_sat - CW'(1));
                    pending_next = 1'b0;
                    flag_next    = 1'b0;
                    state_next   = (n_sat == '0) ? S_FINISH : S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // fold in the previous edge while this one loads
                flag_next    = final_flag;
                pending_next = 1'b0;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                pending_next = 1'b1;
                idx_next     = idx_reg + AW'(1);
                state_next   = last_edge ? S_FINISH : S_LOAD;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = final_flag;
                    pending_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            last_reg      <= '0;
            pending_reg   <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            pending_reg   <= pending_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            inside_reg    <= inside_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // query point held for the walk
    always_ff @(posedge clk)
    begin
        if (qry_beat)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    // checks on the sequencer
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !qry_beat) |=> (state_reg == S_IDLE))
        else $error("sequencer left idle without a query beat");

    a_pending_place: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (state_reg == S_LOAD || state_reg == S_FINISH))
        else $error("pending edge outside load or finish");

    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (qry_beat && n_sat == '0) |=>
            (state_reg == S_FINISH && !pending_reg && !flag_reg))
        else $error("empty polygon query not answered as outside");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL2) |-> (idx_reg <= last_reg))
        else $error("edge index ran past the last vertex");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire

[sv/pip_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/pip_edge_unit.sv]
// edge crossing datapath around one shared multiplier
`default_nettype none

module pip_edge_unit (
    input  wire logic                clk,
    input  wire pip_pkg::edge_ctrl_t ctrl,
    input  wire pip_pkg::coord_t     px,
    input  wire pip_pkg::coord_t     py,
    input  wire pip_pkg::coord_t     vx,
    input  wire pip_pkg::coord_t     vy,
    output logic                     toggle
);

    pip_pkg::coord_t prev_x_reg;
    pip_pkg::coord_t prev_y_reg;
    pip_pkg::diff_t  a_reg;
    pip_pkg::diff_t  b_reg;
    pip_pkg::diff_t  c_reg;
    pip_pkg::diff_t  dy_reg;
    logic            cross_reg;
    pip_pkg::prod_t  lhs_reg;
    pip_pkg::prod_t  rhs_reg;

    pip_pkg::diff_t  op_a;
    pip_pkg::diff_t  op_b;
    pip_pkg::prod_t  prod;

    // previous vertex, side test and edge differences
    always_ff @(posedge clk)
    begin
        if (ctrl.prime || ctrl.load)
        begin
            prev_x_reg <= vx;
            prev_y_reg <= vy;
        end
        if (ctrl.load)
        begin
            cross_reg <= (vy >= py) != (prev_y_reg >= py);
            dy_reg    <= pip_pkg::DIFF_W'(prev_y_reg) - pip_pkg::DIFF_W'(vy);
            a_reg     <= pip_pkg::DIFF_W'(px) - pip_pkg::DIFF_W'(vx);
            b_reg     <= pip_pkg::DIFF_W'(prev_x_reg) - pip_pkg::DIFF_W'(vx);
            c_reg     <= pip_pkg::DIFF_W'(py) - pip_pkg::DIFF_W'(vy);
        end
    end

    // shared multiplier, operands picked by the sequencer step
    assign op_a = ctrl.mul_rhs ? b_reg : a_reg;
    assign op_b = ctrl.mul_rhs ? c_reg : dy_reg;
    assign prod = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_lhs)
        begin
            lhs_reg <= prod;
        end
        if (ctrl.mul_rhs)
        begin
            rhs_reg <= prod;
        end
    end

    // cross-multiplied compare, direction set by the sign of dy
    always_comb
    begin
        if (dy_reg[pip_pkg::DIFF_W-1])
        begin
            toggle = cross_reg && (lhs_reg >= rhs_reg);
        end
        else
        begin
            toggle = cross_reg && (lhs_reg <= rhs_reg);
        end
    end

endmodule

`default_nettype wire
